// ----- rtl/sce_pkg.sv -----
`default_nettype none

package sce_pkg;

    localparam int MAX_TOWNS_DEF    = 64;
    localparam int MAX_SUBTOURS_DEF = 21;

    localparam int EDGE_NUM_W = 11;
    localparam int TOWN_W     = 6;
    localparam int RANK_W     = 5;
    localparam int LEN_W      = 7;
    localparam int SLOT_W     = 6;

    typedef struct packed {
        logic [EDGE_NUM_W-1:0] num;
        logic [TOWN_W-1:0]     a;
        logic [TOWN_W-1:0]     b;
    } t_edge;

    typedef struct packed {
        logic load_edge;
        logic clr_run;
        logic st_skip;
        logic es_rd_start;
        logic walk_init;
        logic scan;
        logic set_err;
        logic ins_begin;
        logic ins_rd;
        logic ins_shift;
        logic ins_put;
        logic em_init;
        logic tab_rd_em;
        logic em_latch;
        logic wo_rd_em;
        logic es_rd_em;
        logic out_load;
        logic em_next_s;
        logic em_next_r;
    } t_cmd;

    typedef struct packed {
        logic st_done;
        logic st_used;
        logic sc_close;
        logic sc_dead;
        logic tab_full;
        logic ins_j_zero;
        logic ins_greater;
        logic out_free;
        logic em_last_s;
        logic em_last_r;
    } t_sts;

    function automatic logic touches(input t_edge e, input logic [TOWN_W-1:0] ta,
                                     input logic [TOWN_W-1:0] tb);
        return (e.a == ta) || (e.a == tb) || (e.b == ta) || (e.b == tb);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sce_ctrl.sv -----
`default_nettype none

module sce_ctrl
    import sce_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  wire  i_final_edge,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [12:0] {
        S_LOAD    = 13'b0000000000001,
        S_FIND    = 13'b0000000000010,
        S_WALK    = 13'b0000000000100,
        S_SCAN    = 13'b0000000001000,
        S_INS_BEG = 13'b0000000010000,
        S_INS_RD  = 13'b0000000100000,
        S_INS_CMP = 13'b0000001000000,
        S_EM_INIT = 13'b0000010000000,
        S_EM_TAB  = 13'b0000100000000,
        S_EM_LAT  = 13'b0001000000000,
        S_EM_WO   = 13'b0010000000000,
        S_EM_ES   = 13'b0100000000000,
        S_EM_OUT  = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load_edge = 1'b1;
                    if (i_final_edge) n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (i_sts.st_done) begin
                    n_state = S_EM_INIT;
                end else if (i_sts.st_used) begin
                    o_cmd.st_skip = 1'b1;
                end else begin
                    o_cmd.es_rd_start = 1'b1;
                    n_state           = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.sc_close || i_sts.sc_dead) n_state = S_INS_BEG;
            end
            S_INS_BEG: begin
                if (i_sts.tab_full) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = S_EM_INIT;
                end else begin
                    o_cmd.ins_begin = 1'b1;
                    n_state         = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (i_sts.ins_j_zero) begin
                    o_cmd.ins_put = 1'b1;
                    n_state       = S_FIND;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state      = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_sts.ins_greater) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = S_INS_RD;
                end else begin
                    o_cmd.ins_put = 1'b1;
                    n_state       = S_FIND;
                end
            end
            S_EM_INIT: begin
                o_cmd.em_init = 1'b1;
                n_state       = S_EM_TAB;
            end
            S_EM_TAB: begin
                o_cmd.tab_rd_em = 1'b1;
                n_state         = S_EM_LAT;
            end
            S_EM_LAT: begin
                o_cmd.em_latch = 1'b1;
                n_state        = S_EM_WO;
            end
            S_EM_WO: begin
                o_cmd.wo_rd_em = 1'b1;
                n_state        = S_EM_ES;
            end
            S_EM_ES: begin
                o_cmd.es_rd_em = 1'b1;
                n_state        = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.em_last_s && i_sts.em_last_r) begin
                        o_cmd.clr_run = 1'b1;
                        n_state       = S_LOAD;
                    end else if (i_sts.em_last_s) begin
                        o_cmd.em_next_r = 1'b1;
                        n_state         = S_EM_TAB;
                    end else begin
                        o_cmd.em_next_s = 1'b1;
                        n_state         = S_EM_WO;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sce_dp.sv -----
`default_nettype none

module sce_dp
    import sce_pkg::*;
#(
    parameter int MAX_TOWNS    = MAX_TOWNS_DEF,
    parameter int MAX_SUBTOURS = MAX_SUBTOURS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  wire  [EDGE_NUM_W-1:0] i_edge_number,
    input  wire  [TOWN_W-1:0]     i_town_a,
    input  wire  [TOWN_W-1:0]     i_town_b,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [RANK_W-1:0]     o_subtour_rank,
    output logic [LEN_W-1:0]      o_subtour_length,
    output logic [SLOT_W-1:0]     o_edge_slot,
    output logic [EDGE_NUM_W-1:0] o_out_edge_number,
    output logic [TOWN_W-1:0]     o_out_town_a,
    output logic [TOWN_W-1:0]     o_out_town_b,
    output logic                  o_subtour_end,
    output logic                  o_run_end,
    output logic                  o_walk_error
);

    localparam int AW  = $clog2(MAX_TOWNS);
    localparam int CW  = $clog2(MAX_TOWNS + 1);
    localparam int TW  = (MAX_SUBTOURS > 1) ? $clog2(MAX_SUBTOURS) : 1;
    localparam int SW  = $clog2(MAX_SUBTOURS + 1);
    localparam int TBW = AW + CW;

    // memories
    t_edge          r_edge_mem [MAX_TOWNS];
    t_edge          r_es_rd;
    logic [AW-1:0]  r_walk_mem [MAX_TOWNS];
    logic [AW-1:0]  r_wo_rd;
    logic [TBW-1:0] r_tab_mem  [MAX_SUBTOURS];
    logic [TBW-1:0] r_tab_rd;

    // control state
    logic [CW-1:0]        r_edge_cnt;
    logic                 r_err;
    logic [MAX_TOWNS-1:0] r_used;
    logic [CW-1:0]        r_start;
    logic [CW-1:0]        r_wo_ptr;
    logic                 r_rd_vld;
    logic [SW-1:0]        r_sub_cnt;
    logic                 r_out_valid;

    // walk and emit registers
    logic [CW-1:0]     r_i;
    logic [AW-1:0]     r_rd_idx;
    logic [TOWN_W-1:0] r_sa;
    logic [TOWN_W-1:0] r_sb;
    logic [TOWN_W-1:0] r_pa;
    logic [TOWN_W-1:0] r_pb;
    logic [CW-1:0]     r_len;
    logic [AW-1:0]     r_pos;
    logic [TW-1:0]     r_j;
    logic [TW-1:0]     r_r;
    logic [AW-1:0]     r_s;
    logic [AW-1:0]     r_em_start;
    logic [CW-1:0]     r_em_len;

    logic           edge_room;
    logic           edge_we;
    logic           cand_ok;
    logic           match;
    logic           close;
    logic           dead;
    logic           es_en;
    logic [AW-1:0]  es_addr;
    logic           wo_we;
    logic [AW-1:0]  wo_wd;
    logic           tab_we;
    logic [TBW-1:0] tab_wd;
    logic           last_s;
    logic           last_r;

    assign edge_room = (r_edge_cnt < CW'(MAX_TOWNS));
    assign edge_we   = i_cmd.load_edge && edge_room;
    assign cand_ok   = (r_i < r_edge_cnt);
    assign match     = r_rd_vld && touches(r_es_rd, r_pa, r_pb);
    assign close     = match && (r_len >= CW'(2)) && touches(r_es_rd, r_sa, r_sb);
    assign dead      = !r_rd_vld && !cand_ok;

    assign last_s = ((CW'(r_s) + CW'(1)) == r_em_len);
    assign last_r = ((SW'(r_r) + SW'(1)) == r_sub_cnt);

    always_comb begin
        es_en   = 1'b0;
        es_addr = r_start[AW-1:0];
        priority if (i_cmd.es_rd_start) begin
            es_en   = 1'b1;
            es_addr = r_start[AW-1:0];
        end else if (i_cmd.scan && !match && cand_ok) begin
            es_en   = 1'b1;
            es_addr = r_i[AW-1:0];
        end else if (i_cmd.es_rd_em) begin
            es_en   = 1'b1;
            es_addr = r_wo_rd;
        end
    end

    assign wo_we  = i_cmd.walk_init || (i_cmd.scan && match);
    assign wo_wd  = i_cmd.walk_init ? r_start[AW-1:0] : r_rd_idx;
    assign tab_we = i_cmd.ins_put || i_cmd.ins_shift;
    assign tab_wd = i_cmd.ins_shift ? r_tab_rd : {r_pos, r_len};

    assign o_sts.st_done     = (r_start >= r_edge_cnt);
    assign o_sts.st_used     = r_used[r_start[AW-1:0]];
    assign o_sts.sc_close    = close;
    assign o_sts.sc_dead     = dead;
    assign o_sts.tab_full    = (r_sub_cnt >= SW'(MAX_SUBTOURS));
    assign o_sts.ins_j_zero  = (r_j == '0);
    assign o_sts.ins_greater = (r_tab_rd[CW-1:0] > r_len);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.em_last_s   = last_s;
    assign o_sts.em_last_r   = last_r;

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[r_edge_cnt[AW-1:0]] <= '{num: i_edge_number, a: i_town_a, b: i_town_b};
        end
        if (es_en) begin
            r_es_rd <= r_edge_mem[es_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wo_we) begin
            r_walk_mem[r_wo_ptr[AW-1:0]] <= wo_wd;
        end
        if (i_cmd.wo_rd_em) begin
            r_wo_rd <= r_walk_mem[r_em_start + r_s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[r_j] <= tab_wd;
        end
        if (i_cmd.ins_rd) begin
            r_tab_rd <= r_tab_mem[r_j - TW'(1)];
        end else if (i_cmd.tab_rd_em) begin
            r_tab_rd <= r_tab_mem[r_r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt  <= '0;
            r_err       <= 1'b0;
            r_used      <= '0;
            r_start     <= '0;
            r_wo_ptr    <= '0;
            r_rd_vld    <= 1'b0;
            r_sub_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_edge) begin
                if (edge_room) begin
                    r_edge_cnt <= r_edge_cnt + CW'(1);
                end else begin
                    r_err <= 1'b1;
                end
            end
            if (i_cmd.st_skip) begin
                r_start <= r_start + CW'(1);
            end
            if (i_cmd.walk_init) begin
                r_used[r_start[AW-1:0]] <= 1'b1;
                r_wo_ptr                <= r_wo_ptr + CW'(1);
                r_rd_vld                <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (match) begin
                    r_used[r_rd_idx] <= 1'b1;
                    r_wo_ptr         <= r_wo_ptr + CW'(1);
                    r_rd_vld         <= 1'b0;
                end else begin
                    r_rd_vld <= cand_ok && !r_used[r_i[AW-1:0]];
                end
                if (dead) begin
                    r_err <= 1'b1;
                end
            end
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
            if (i_cmd.ins_put) begin
                r_sub_cnt <= r_sub_cnt + SW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clr_run) begin
                r_edge_cnt <= '0;
                r_err      <= 1'b0;
                r_used     <= '0;
                r_start    <= '0;
                r_wo_ptr   <= '0;
                r_sub_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_sa  <= r_es_rd.a;
            r_sb  <= r_es_rd.b;
            r_pa  <= r_es_rd.a;
            r_pb  <= r_es_rd.b;
            r_len <= CW'(1);
            r_pos <= r_wo_ptr[AW-1:0];
            r_i   <= r_start + CW'(1);
        end
        if (i_cmd.scan) begin
            if (match) begin
                r_pa  <= r_es_rd.a;
                r_pb  <= r_es_rd.b;
                r_len <= r_len + CW'(1);
                r_i   <= r_start + CW'(1);
            end else if (cand_ok) begin
                r_rd_idx <= r_i[AW-1:0];
                r_i      <= r_i + CW'(1);
            end
        end
        if (i_cmd.ins_begin) begin
            r_j <= r_sub_cnt[TW-1:0];
        end else if (i_cmd.ins_shift) begin
            r_j <= r_j - TW'(1);
        end
        if (i_cmd.em_init) begin
            r_r <= '0;
        end else if (i_cmd.em_next_r) begin
            r_r <= r_r + TW'(1);
        end
        if (i_cmd.em_latch) begin
            r_em_start <= r_tab_rd[TBW-1:CW];
            r_em_len   <= r_tab_rd[CW-1:0];
            r_s        <= '0;
        end else if (i_cmd.em_next_s) begin
            r_s <= r_s + AW'(1);
        end
        if (i_cmd.out_load) begin
            o_subtour_rank    <= RANK_W'(r_r);
            o_subtour_length  <= LEN_W'(r_em_len);
            o_edge_slot       <= SLOT_W'(r_s);
            o_out_edge_number <= r_es_rd.num;
            o_out_town_a      <= r_es_rd.a;
            o_out_town_b      <= r_es_rd.b;
            o_subtour_end     <= last_s;
            o_run_end         <= last_s && last_r;
            o_walk_error      <= r_err;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/subtour_cycle_extractor.sv -----
`default_nettype none

// channel | handshake                      | payload
// --------+--------------------------------+---------------------------------------------
// in      | i_in_valid / o_in_ready        | i_edge_number, i_town_a, i_town_b,
//         |                                | i_final_edge
// out     | o_out_valid / i_out_ready      | o_subtour_rank, o_subtour_length, o_edge_slot,
//         |                                | o_out_edge_number, o_out_town_a, o_out_town_b,
//         |                                | o_subtour_end, o_run_end, o_walk_error
//
// edges load one per cycle; the flagged request starts extraction and input stalls until
// the last result sits in the output register
// extraction: start search over the stored edges; walk steps read candidates through the
// edge store read port, rescanned from the walk start; sorted insert reads and compares
// each shifted entry; emission: per result S_EM_WO, S_EM_ES, S_EM_OUT, with S_EM_TAB and
// S_EM_LAT at the start of each subtour, plus any stall
// synchronous active-low reset clears control state only; no clearing pass

module subtour_cycle_extractor
    import sce_pkg::*;
#(
    parameter int MAX_TOWNS    = MAX_TOWNS_DEF,
    parameter int MAX_SUBTOURS = MAX_SUBTOURS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire  [EDGE_NUM_W-1:0] i_edge_number,
    input  wire  [TOWN_W-1:0]     i_town_a,
    input  wire  [TOWN_W-1:0]     i_town_b,
    input  wire                   i_final_edge,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [RANK_W-1:0]     o_subtour_rank,
    output logic [LEN_W-1:0]      o_subtour_length,
    output logic [SLOT_W-1:0]     o_edge_slot,
    output logic [EDGE_NUM_W-1:0] o_out_edge_number,
    output logic [TOWN_W-1:0]     o_out_town_a,
    output logic [TOWN_W-1:0]     o_out_town_b,
    output logic                  o_subtour_end,
    output logic                  o_run_end,
    output logic                  o_walk_error
);

    t_cmd cmd;
    t_sts sts;

    sce_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_edge (i_final_edge),
        .o_in_ready   (o_in_ready),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    sce_dp #(
        .MAX_TOWNS    (MAX_TOWNS),
        .MAX_SUBTOURS (MAX_SUBTOURS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_edge_number     (i_edge_number),
        .i_town_a          (i_town_a),
        .i_town_b          (i_town_b),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_subtour_rank    (o_subtour_rank),
        .o_subtour_length  (o_subtour_length),
        .o_edge_slot       (o_edge_slot),
        .o_out_edge_number (o_out_edge_number),
        .o_out_town_a      (o_out_town_a),
        .o_out_town_b      (o_out_town_b),
        .o_subtour_end     (o_subtour_end),
        .o_run_end         (o_run_end),
        .o_walk_error      (o_walk_error)
    );

endmodule

`default_nettype wire

// ----- bench/subtour_checker.sv -----
`timescale 1ns / 1ps

module subtour_checker
    import sce_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  wire [EDGE_NUM_W-1:0] i_edge_number,
    input  wire [TOWN_W-1:0]     i_town_a,
    input  wire [TOWN_W-1:0]     i_town_b,
    input  wire                  i_final_edge,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  wire [RANK_W-1:0]     i_subtour_rank,
    input  wire [LEN_W-1:0]      i_subtour_length,
    input  wire [SLOT_W-1:0]     i_edge_slot,
    input  wire [EDGE_NUM_W-1:0] i_out_edge_number,
    input  wire [TOWN_W-1:0]     i_out_town_a,
    input  wire [TOWN_W-1:0]     i_out_town_b,
    input  wire                  i_subtour_end,
    input  wire                  i_run_end,
    input  wire                  i_walk_error,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int N_SLOTS = MAX_TOWNS_DEF;
    localparam int N_TOURS = MAX_SUBTOURS_DEF;

    typedef struct packed {
        logic [RANK_W-1:0]     rank;
        logic [LEN_W-1:0]      len;
        logic [SLOT_W-1:0]     slot;
        logic [EDGE_NUM_W-1:0] num;
        logic [TOWN_W-1:0]     ta;
        logic [TOWN_W-1:0]     tb;
        logic                  sub_end;
        logic                  last;
        logic                  err;
    } t_tour_edge;

    t_edge      held_edges [N_SLOTS];
    bit         taken      [N_SLOTS];
    int         walk_seq   [N_SLOTS];
    int         tour_start [N_TOURS];
    int         tour_len   [N_TOURS];
    int         n_held    = 0;
    int         n_tours   = 0;
    bit         run_fault = 1'b0;
    int         fails     = 0;
    int         n_seen    = 0;
    t_tour_edge tour_edges_due [$];

    initial o_pending = 0;
    assign o_fail_count = fails;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fails++;
    endtask

    function automatic bit shares_town(input int x, input int y);
        t_edge p;
        t_edge q;
        p = held_edges[x];
        q = held_edges[y];
        return (p.a == q.a) || (p.a == q.b) || (p.b == q.a) || (p.b == q.b);
    endfunction

    // walks the held edges into closed subtours, table kept sorted by length
    task automatic split_subtours();
        int pos;
        int first;
        int cnt;
        int prev;
        int k;
        bit hit;
        pos = 0;
        while (1) begin
            first = 0;
            while (first < n_held && taken[first]) first++;
            if (first >= n_held) break;
            walk_seq[pos] = first;
            taken[first] = 1'b1;
            cnt = 1;
            prev = first;
            while (1) begin
                hit = 1'b0;
                for (int i = first + 1; i < n_held; i++) begin
                    if (!taken[i] && shares_town(i, prev)) begin
                        walk_seq[pos + cnt] = i;
                        cnt++;
                        taken[i] = 1'b1;
                        prev = i;
                        hit = 1'b1;
                        break;
                    end
                end
                if (cnt > 2 && shares_town(first, prev)) break;
                if (!hit) begin
                    run_fault = 1'b1;
                    break;
                end
            end
            if (n_tours >= N_TOURS) begin
                run_fault = 1'b1;
                break;
            end
            k = n_tours;
            for (int i = 0; i < n_tours; i++) begin
                if (cnt < tour_len[i]) begin
                    k = i;
                    break;
                end
            end
            for (int i = n_tours; i > k; i--) begin
                tour_start[i] = tour_start[i-1];
                tour_len[i]   = tour_len[i-1];
            end
            tour_start[k] = pos;
            tour_len[k]   = cnt;
            n_tours++;
            pos += cnt;
        end
    endtask

    task automatic take_request(input t_edge e, input bit fin);
        int total;
        int idx;
        int e_i;
        t_tour_edge item;
        if (n_held < N_SLOTS) begin
            held_edges[n_held] = e;
            n_held++;
        end else begin
            run_fault = 1'b1;
        end
        if (!fin) return;
        split_subtours();
        total = 0;
        for (int r = 0; r < n_tours; r++) total += tour_len[r];
        idx = 0;
        for (int r = 0; r < n_tours; r++) begin
            for (int s = 0; s < tour_len[r]; s++) begin
                e_i          = walk_seq[tour_start[r] + s];
                item.rank    = RANK_W'(r);
                item.len     = LEN_W'(tour_len[r]);
                item.slot    = SLOT_W'(s);
                item.num     = held_edges[e_i].num;
                item.ta      = held_edges[e_i].a;
                item.tb      = held_edges[e_i].b;
                item.sub_end = (s + 1 == tour_len[r]);
                item.last    = (idx + 1 == total);
                item.err     = run_fault;
                tour_edges_due.push_back(item);
                idx++;
            end
        end
        n_held    = 0;
        n_tours   = 0;
        run_fault = 1'b0;
        foreach (taken[i]) taken[i] = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_edge      req;
        t_tour_edge got;
        t_tour_edge want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                req.num = i_edge_number;
                req.a   = i_town_a;
                req.b   = i_town_b;
                take_request(req, i_final_edge);
            end
            if (i_out_valid && i_out_ready) begin
                got.rank    = i_subtour_rank;
                got.len     = i_subtour_length;
                got.slot    = i_edge_slot;
                got.num     = i_out_edge_number;
                got.ta      = i_out_town_a;
                got.tb      = i_out_town_b;
                got.sub_end = i_subtour_end;
                got.last    = i_run_end;
                got.err     = i_walk_error;
                if (tour_edges_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected", n_seen));
                end else begin
                    want = tour_edges_due.pop_front();
                    if (got.rank !== want.rank)
                        report_mismatch($sformatf("result %0d subtour_rank %0d, want %0d",
                                                  n_seen, got.rank, want.rank));
                    if (got.len !== want.len)
                        report_mismatch($sformatf("result %0d subtour_length %0d, want %0d",
                                                  n_seen, got.len, want.len));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("result %0d edge_slot %0d, want %0d",
                                                  n_seen, got.slot, want.slot));
                    if (got.num !== want.num)
                        report_mismatch($sformatf("result %0d out_edge_number %0d, want %0d",
                                                  n_seen, got.num, want.num));
                    if (got.ta !== want.ta)
                        report_mismatch($sformatf("result %0d out_town_a %0d, want %0d",
                                                  n_seen, got.ta, want.ta));
                    if (got.tb !== want.tb)
                        report_mismatch($sformatf("result %0d out_town_b %0d, want %0d",
                                                  n_seen, got.tb, want.tb));
                    if (got.sub_end !== want.sub_end)
                        report_mismatch($sformatf("result %0d subtour_end %b, want %b",
                                                  n_seen, got.sub_end, want.sub_end));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("result %0d run_end %b, want %b",
                                                  n_seen, got.last, want.last));
                    if (got.err !== want.err)
                        report_mismatch($sformatf("result %0d walk_error %b, want %b",
                                                  n_seen, got.err, want.err));
                end
                n_seen++;
            end
        end
        o_pending <= tour_edges_due.size();
    end

endmodule

// ----- bench/tb_subtour_cycle_extractor.sv -----
`timescale 1ns / 1ps

module tb_subtour_cycle_extractor;
    import sce_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 450;
    localparam int ITEM_TARGET = 170;

    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE} t_rx_mode;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [EDGE_NUM_W-1:0] edge_number;
    logic [TOWN_W-1:0]     town_a;
    logic [TOWN_W-1:0]     town_b;
    logic                  final_edge;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [RANK_W-1:0]     subtour_rank;
    logic [LEN_W-1:0]      subtour_length;
    logic [SLOT_W-1:0]     edge_slot;
    logic [EDGE_NUM_W-1:0] out_edge_number;
    logic [TOWN_W-1:0]     out_town_a;
    logic [TOWN_W-1:0]     out_town_b;
    logic                  subtour_end;
    logic                  run_end;
    logic                  walk_error;

    int       fail_count;
    int       pending;
    int       cycles      = 0;
    int       burst_left  = 0;
    int       sent        = 0;
    int       hold_asks   = 0;
    int       hold_served = 0;
    int       hold_left   = 0;
    int       mode_left   = 0;
    t_rx_mode rx_mode     = RX_STEADY;
    t_edge    set_q  [$];
    int       town_q [$];

    subtour_cycle_extractor u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_edge_number     (edge_number),
        .i_town_a          (town_a),
        .i_town_b          (town_b),
        .i_final_edge      (final_edge),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_subtour_rank    (subtour_rank),
        .o_subtour_length  (subtour_length),
        .o_edge_slot       (edge_slot),
        .o_out_edge_number (out_edge_number),
        .o_out_town_a      (out_town_a),
        .o_out_town_b      (out_town_b),
        .o_subtour_end     (subtour_end),
        .o_run_end         (run_end),
        .o_walk_error      (walk_error)
    );

    subtour_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_edge_number     (edge_number),
        .i_town_a          (town_a),
        .i_town_b          (town_b),
        .i_final_edge      (final_edge),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_subtour_rank    (subtour_rank),
        .i_subtour_length  (subtour_length),
        .i_edge_slot       (edge_slot),
        .i_out_edge_number (out_edge_number),
        .i_out_town_a      (out_town_a),
        .i_out_town_b      (out_town_b),
        .i_subtour_end     (subtour_end),
        .i_run_end         (run_end),
        .i_walk_error      (walk_error),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_subtour_cycle_extractor failed");
            $finish;
        end
    end

    // result side: long hold-off on request, otherwise a changing stall pattern
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_served) begin
            out_ready   <= 1'b0;
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 2));
                mode_left <= $urandom_range(5, 60);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_STEADY: out_ready <= 1'b1;
                RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
                default:   out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic t_edge mk_edge(input int num, input int a, input int b);
        t_edge e;
        e.num = EDGE_NUM_W'(num);
        e.a   = TOWN_W'(a);
        e.b   = TOWN_W'(b);
        return e;
    endfunction

    task automatic shuffle_set();
        int j;
        t_edge tmp;
        for (int i = set_q.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = set_q[i];
            set_q[i] = set_q[j];
            set_q[j] = tmp;
        end
    endtask

    // k distinct towns split into closed loops of three or more
    task automatic add_loops(input int k, input bit one_loop);
        int j;
        int tmp;
        int rem;
        int n;
        int base;
        int a;
        int b;
        town_q = {};
        for (int t = 0; t < 64; t++) town_q.push_back(t);
        for (int i = 63; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = town_q[i];
            town_q[i] = town_q[j];
            town_q[j] = tmp;
        end
        base = 0;
        rem = k;
        while (rem > 0) begin
            if (one_loop || rem < 6) n = rem;
            else n = $urandom_range(3, rem - 3);
            for (int i = 0; i < n; i++) begin
                a = town_q[base + i];
                b = town_q[base + (i + 1) % n];
                if ($urandom_range(0, 1) == 1) set_q.push_back(mk_edge($urandom_range(0, 2047), b, a));
                else set_q.push_back(mk_edge($urandom_range(0, 2047), a, b));
            end
            base += n;
            rem -= n;
        end
    endtask

    task automatic add_noise(input int n);
        int top_town;
        top_town = $urandom_range(3, 63);
        for (int i = 0; i < n; i++)
            set_q.push_back(mk_edge($urandom_range(0, 2047), $urandom_range(0, top_town),
                                    $urandom_range(0, top_town)));
    endtask

    task automatic offer_edge(input t_edge e, input bit fin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        edge_number <= e.num;
        town_a      <= e.a;
        town_b      <= e.b;
        final_edge  <= fin;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        sent++;
    endtask

    task automatic send_set();
        foreach (set_q[i]) offer_edge(set_q[i], i == set_q.size() - 1);
    endtask

    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int pick;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        edge_number = '0;
        town_a      = '0;
        town_b      = '0;
        final_edge  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // triangle at the field extremes
        set_q = {};
        set_q.push_back(mk_edge(2047, 63, 0));
        set_q.push_back(mk_edge(2015, 0, 62));
        set_q.push_back(mk_edge(1024, 62, 63));
        send_set();
        drain_results();

        // isolated edges: every walk dies, the table overflows
        set_q = {};
        for (int i = 0; i < 22; i++)
            set_q.push_back(mk_edge((i == 0) ? 0 : $urandom_range(0, 2047), 2 * i, 2 * i + 1));
        send_set();
        drain_results();

        // hold the result side while more requests pile up
        hold_asks <= hold_asks + 1;
        set_q = {};
        add_loops(9, 1'b0);
        shuffle_set();
        send_set();

        // one loop over every town, then two requests past the store
        set_q = {};
        add_loops(64, 1'b1);
        shuffle_set();
        add_noise(2);
        send_set();
        drain_results();

        while (sent < ITEM_TARGET) begin
            set_q = {};
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                add_loops($urandom_range(3, 12), $urandom_range(0, 3) == 0);
            end else if (pick <= 7) begin
                add_noise($urandom_range(1, 8));
            end else if (pick == 8) begin
                add_loops($urandom_range(3, 12), 1'b0);
                set_q.delete($urandom_range(0, set_q.size() - 1));
            end else begin
                add_loops($urandom_range(3, 9), 1'b0);
                add_noise($urandom_range(1, 3));
            end
            shuffle_set();
            send_set();
            if ($urandom_range(0, 4) == 0) drain_results();
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_subtour_cycle_extractor passed");
        end else begin
            $display("tb_subtour_cycle_extractor failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sce_pkg.sv
rtl/sce_ctrl.sv
rtl/sce_dp.sv
rtl/subtour_cycle_extractor.sv
bench/subtour_checker.sv
bench/tb_subtour_cycle_extractor.sv
